// ===== rtl/qrs_pkg.sv =====
// Shared widths, codes and stage records for the quadratic root solver.
// Used by every module under rtl; depends on nothing else.
`timescale 1ns / 1ps

package qrs_pkg;

    localparam int COEF_WIDTH   = 16;
    localparam int RESULT_WIDTH = 32;
    localparam int RES_FRAC     = 16;

    // Discriminant magnitude, integer root and divider widths.
    localparam int DMAG_WIDTH = 2 * COEF_WIDTH + 1;
    localparam int RAD_WIDTH  = 2 * DMAG_WIDTH;
    localparam int ROOT_WIDTH = DMAG_WIDTH;
    localparam int SREM_WIDTH = ROOT_WIDTH + 2;
    localparam int NB_WIDTH   = COEF_WIDTH + RES_FRAC + 1;
    localparam int NUM_WIDTH  = ROOT_WIDTH + 2;
    localparam int NMAG_WIDTH = NUM_WIDTH - 1;
    localparam int DEN_WIDTH  = COEF_WIDTH + 1;
    localparam int SQRT_CELLS = RAD_WIDTH / 2;
    localparam int DIV_CELLS  = NMAG_WIDTH;

    typedef enum logic [1:0] {
        KIND_TWO_REAL = 2'd0,
        KIND_COMPLEX  = 2'd1,
        KIND_DOUBLE   = 2'd2,
        KIND_A_ZERO   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                       kind;
        logic                        a_neg;
        logic [DEN_WIDTH-1:0]        den_mag;
        logic signed [NB_WIDTH-1:0]  nb;
    } side_t;

    typedef struct packed {
        side_t                   side;
        logic [RAD_WIDTH-1:0]    rad;
        logic [SREM_WIDTH-1:0]   rem;
        logic [ROOT_WIDTH-1:0]   root;
    } sqrt_t;

    typedef struct packed {
        kind_t                   kind;
        logic [DEN_WIDTH-1:0]    den_mag;
        logic [NMAG_WIDTH-1:0]   num1;
        logic [DEN_WIDTH-1:0]    rem1;
        logic                    neg1;
        logic [NMAG_WIDTH-1:0]   num2;
        logic [DEN_WIDTH-1:0]    rem2;
        logic                    neg2;
    } div_t;

endpackage

// ===== rtl/qrs_front.sv =====
// Front stages: squares and products, then the discriminant and root kind.
// Depends on qrs_pkg.
`timescale 1ns / 1ps

module qrs_front (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  logic                                    vin,
    input  logic signed [qrs_pkg::COEF_WIDTH-1:0]   coef_a,
    input  logic signed [qrs_pkg::COEF_WIDTH-1:0]   coef_b,
    input  logic signed [qrs_pkg::COEF_WIDTH-1:0]   coef_c,
    output logic                                    vout,
    output qrs_pkg::sqrt_t                          dout
);

    localparam int CW = qrs_pkg::COEF_WIDTH;
    localparam int DW = qrs_pkg::DMAG_WIDTH;
    localparam int PW = 2 * CW;
    localparam int EW = qrs_pkg::DEN_WIDTH;

    logic                       va_reg;
    logic signed [CW-1:0]       a_reg;
    logic signed [CW-1:0]       b_reg;
    logic signed [2*CW-1:0]     b2_reg;
    logic signed [2*CW-1:0]     ac_reg;
    logic                       vb_reg;
    qrs_pkg::sqrt_t             out_reg;
    qrs_pkg::sqrt_t             out_next;
    logic signed [DW:0]         d;
    logic [DW-1:0]              d_mag;
    logic [EW-1:0]              a2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= vin;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg   <= coef_a;
            b_reg   <= coef_b;
            b2_reg  <= PW'(coef_b) * PW'(coef_b);
            ac_reg  <= PW'(coef_a) * PW'(coef_c);
            out_reg <= out_next;
        end
    end

    always_comb
    begin
        d     = {{(DW-2*CW+1){1'b0}}, b2_reg} - {ac_reg, 2'b00};
        d_mag = d[DW] ? DW'(-d) : d[DW-1:0];
        a2    = {a_reg, 1'b0};
        out_next.side.a_neg   = a_reg[CW-1];
        out_next.side.den_mag = a2[EW-1] ? EW'(-a2) : a2;
        out_next.side.nb      = -({{(qrs_pkg::NB_WIDTH-CW){b_reg[CW-1]}}, b_reg}
                                  <<< qrs_pkg::RES_FRAC);
        if (a_reg == '0)
            out_next.side.kind = qrs_pkg::KIND_A_ZERO;
        else if (d_mag == '0)
            out_next.side.kind = qrs_pkg::KIND_DOUBLE;
        else if (d[DW])
            out_next.side.kind = qrs_pkg::KIND_COMPLEX;
        else
            out_next.side.kind = qrs_pkg::KIND_TWO_REAL;
        // The radicand is the discriminant magnitude scaled by 2^32.
        out_next.rad  = {1'b0, d_mag, {(qrs_pkg::RAD_WIDTH-DW-1){1'b0}}};
        out_next.rem  = '0;
        out_next.root = '0;
    end

    assign vout = vb_reg;
    assign dout = out_reg;

endmodule

// ===== rtl/qrs_sqrt_cell.sv =====
// One cell of the integer square root chain: consumes the top bit pair of
// the radicand and settles one root bit. Depends on qrs_pkg.
`timescale 1ns / 1ps

module qrs_sqrt_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            vin,
    input  qrs_pkg::sqrt_t  din,
    output logic            vout,
    output qrs_pkg::sqrt_t  dout
);

    localparam int RW = qrs_pkg::SREM_WIDTH;
    localparam int AW = qrs_pkg::RAD_WIDTH;
    localparam int TW = qrs_pkg::ROOT_WIDTH;

    logic               v_reg;
    qrs_pkg::sqrt_t     d_reg;
    qrs_pkg::sqrt_t     d_next;
    logic [RW+1:0]      remw;
    logic [RW+1:0]      trial;
    logic               ge;

    always_comb
    begin
        remw  = {din.rem, din.rad[AW-1:AW-2]};
        trial = {{(RW-TW){1'b0}}, din.root, 2'b01};
        ge    = remw >= trial;
        d_next.side = din.side;
        d_next.rad  = {din.rad[AW-3:0], 2'b00};
        d_next.rem  = ge ? RW'(remw - trial) : RW'(remw);
        d_next.root = {din.root[TW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    assign vout = v_reg;
    assign dout = d_reg;

endmodule

// ===== rtl/qrs_div_cell.sv =====
// One cell of the two-lane restoring divider chain: one quotient bit per
// lane per cell. Depends on qrs_pkg.
`timescale 1ns / 1ps

module qrs_div_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            vin,
    input  qrs_pkg::div_t   din,
    output logic            vout,
    output qrs_pkg::div_t   dout
);

    localparam int DW = qrs_pkg::DEN_WIDTH;
    localparam int NW = qrs_pkg::NMAG_WIDTH;

    logic           v_reg;
    qrs_pkg::div_t  d_reg;
    qrs_pkg::div_t  d_next;
    logic [DW:0]    w1;
    logic [DW:0]    w2;
    logic           ge1;
    logic           ge2;

    always_comb
    begin
        w1  = {din.rem1, din.num1[NW-1]};
        w2  = {din.rem2, din.num2[NW-1]};
        ge1 = w1 >= {1'b0, din.den_mag};
        ge2 = w2 >= {1'b0, din.den_mag};
        d_next         = din;
        d_next.rem1    = ge1 ? DW'(w1 - {1'b0, din.den_mag}) : DW'(w1);
        d_next.rem2    = ge2 ? DW'(w2 - {1'b0, din.den_mag}) : DW'(w2);
        d_next.num1    = {din.num1[NW-2:0], ge1};
        d_next.num2    = {din.num2[NW-2:0], ge2};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    assign vout = v_reg;
    assign dout = d_reg;

endmodule

// ===== rtl/quadratic_root_solver.sv =====
// Top level of the quadratic root solver: front stages, square root chain,
// numerator stage, divider chain and output register. Depends on qrs_pkg and the qrs_ cells.
`timescale 1ns / 1ps

// Usage:
// Each input transfer carries signed Q8.8 coefficients coef_a, coef_b and
// coef_c. Each one yields exactly one output transfer with root_kind
// (two real, complex pair, double root, or a equal to zero) and two signed
// Q16.16 values, truncated toward zero and saturated.
// The pipeline holds two front stages for the products and the
// discriminant, 33 square root cells, one numerator stage, 34 divider cells
// and the output register. One item enters per cycle while in_stall is low;
// the square root and divider cells each settle one bit, which sets the depth.
// When the receiver holds out_stall with a result waiting, the whole pipeline
// freezes and in_stall rises in the same cycle; the held result stays put.
// Reset empties every stage at once; no result is pending afterward.
module quadratic_root_solver (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic signed [qrs_pkg::COEF_WIDTH-1:0]     coef_a,
    input  logic signed [qrs_pkg::COEF_WIDTH-1:0]     coef_b,
    input  logic signed [qrs_pkg::COEF_WIDTH-1:0]     coef_c,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic [1:0]                                root_kind,
    output logic signed [qrs_pkg::RESULT_WIDTH-1:0]   first_value,
    output logic signed [qrs_pkg::RESULT_WIDTH-1:0]   second_value
);

    localparam int NS = qrs_pkg::SQRT_CELLS;
    localparam int ND = qrs_pkg::DIV_CELLS;
    localparam int NW = qrs_pkg::NUM_WIDTH;
    localparam int MW = qrs_pkg::NMAG_WIDTH;
    localparam int OW = qrs_pkg::RESULT_WIDTH;

    logic                   en;
    logic                   sv   [NS+1];
    qrs_pkg::sqrt_t         sd   [NS+1];
    logic                   dv   [ND+1];
    qrs_pkg::div_t          dd   [ND+1];
    logic                   nv_reg;
    qrs_pkg::div_t          n_reg;
    qrs_pkg::div_t          n_next;
    logic signed [NW-1:0]   nbx;
    logic signed [NW-1:0]   sx;
    logic signed [NW-1:0]   n1;
    logic signed [NW-1:0]   n2;
    logic                   ov_reg;
    logic [1:0]             kind_reg;
    logic [OW-1:0]          v1_reg;
    logic [OW-1:0]          v2_reg;
    logic [OW-1:0]          v1_next;
    logic [OW-1:0]          v2_next;

    function automatic logic [qrs_pkg::RESULT_WIDTH-1:0] sat_out(
        input logic [qrs_pkg::NMAG_WIDTH-1:0] q,
        input logic                           neg
    );
        logic [qrs_pkg::NMAG_WIDTH-1:0] lim;
        logic [qrs_pkg::NMAG_WIDTH-1:0] qs;
        lim = {{(qrs_pkg::NMAG_WIDTH-qrs_pkg::RESULT_WIDTH+1){1'b0}},
               {(qrs_pkg::RESULT_WIDTH-1){1'b1}}} + qrs_pkg::NMAG_WIDTH'(neg);
        qs  = (q > lim) ? lim : q;
        return neg ? qrs_pkg::RESULT_WIDTH'(-qs) : qrs_pkg::RESULT_WIDTH'(qs);
    endfunction

    assign en       = !(ov_reg && out_stall);
    assign in_stall = !en;

    qrs_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .vin    (in_valid),
        .coef_a (coef_a),
        .coef_b (coef_b),
        .coef_c (coef_c),
        .vout   (sv[0]),
        .dout   (sd[0])
    );

    for (genvar i = 0; i < NS; i++)
    begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .vin   (sv[i]),
            .din   (sd[i]),
            .vout  (sv[i+1]),
            .dout  (sd[i+1])
        );
    end

    // Numerators for both divider lanes, chosen by the root kind.
    always_comb
    begin
        nbx = {{(NW-qrs_pkg::NB_WIDTH){sd[NS].side.nb[qrs_pkg::NB_WIDTH-1]}},
               sd[NS].side.nb};
        sx  = {{(NW-qrs_pkg::ROOT_WIDTH){1'b0}}, sd[NS].root};
        unique case (sd[NS].side.kind)
            qrs_pkg::KIND_TWO_REAL:
            begin
                n1 = nbx + sx;
                n2 = nbx - sx;
            end
            qrs_pkg::KIND_COMPLEX:
            begin
                n1 = nbx;
                n2 = sx;
            end
            default:
            begin
                n1 = nbx;
                n2 = nbx;
            end
        endcase
        n_next.kind    = sd[NS].side.kind;
        n_next.den_mag = sd[NS].side.den_mag;
        n_next.num1    = n1[NW-1] ? MW'(-n1) : n1[MW-1:0];
        n_next.num2    = n2[NW-1] ? MW'(-n2) : n2[MW-1:0];
        n_next.neg1    = n1[NW-1] ^ sd[NS].side.a_neg;
        n_next.neg2    = n2[NW-1] ^ sd[NS].side.a_neg;
        n_next.rem1    = '0;
        n_next.rem2    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            nv_reg <= sv[NS];
            ov_reg <= dv[ND];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg    <= n_next;
            kind_reg <= dd[ND].kind;
            v1_reg   <= v1_next;
            v2_reg   <= v2_next;
        end
    end

    assign dv[0] = nv_reg;
    assign dd[0] = n_reg;

    for (genvar j = 0; j < ND; j++)
    begin : g_div
        qrs_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .vin   (dv[j]),
            .din   (dd[j]),
            .vout  (dv[j+1]),
            .dout  (dd[j+1])
        );
    end

    always_comb
    begin
        if (dd[ND].kind == qrs_pkg::KIND_A_ZERO)
        begin
            v1_next = '0;
            v2_next = '0;
        end
        else
        begin
            v1_next = sat_out(dd[ND].num1, dd[ND].neg1);
            v2_next = sat_out(dd[ND].num2, dd[ND].neg2);
        end
    end

    assign out_valid    = ov_reg;
    assign root_kind    = kind_reg;
    assign first_value  = v1_reg;
    assign second_value = v2_reg;

endmodule

// ===== rtl/qrs_checker.sv =====
// Port-level checks for the quadratic root solver, bound to the top level.
// Depends on qrs_pkg and quadratic_root_solver.
`timescale 1ns / 1ps

module qrs_checker (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    input  logic                                      in_stall,
    input  logic                                      out_valid,
    input  logic                                      out_stall,
    input  logic [1:0]                                root_kind,
    input  logic signed [qrs_pkg::RESULT_WIDTH-1:0]   first_value,
    input  logic signed [qrs_pkg::RESULT_WIDTH-1:0]   second_value
);

    // A held result must not move or vanish.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(first_value)
            && $stable(second_value) && $stable(root_kind))
    else $error("held result changed");

    // The input side only backs up when a result is blocked at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && root_kind == qrs_pkg::KIND_A_ZERO
            |-> first_value == '0 && second_value == '0)
    else $error("nonzero values with a zero leading coefficient");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && root_kind == qrs_pkg::KIND_DOUBLE |-> first_value == second_value)
    else $error("double root values differ");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .root_kind    (root_kind),
    .first_value  (first_value),
    .second_value (second_value)
);

// ===== test/quadratic_root_solver_tb.sv =====
// Self-checking testbench for the quadratic root solver: drives coefficient
// sets, predicts the root kind and values, and compares every output transfer.
// Depends on qrs_pkg and the quadratic_root_solver RTL.
`timescale 1ns / 1ps

module quadratic_root_solver_tb;

    typedef struct {
        qrs_pkg::kind_t kind;
        logic [31:0]    first;
        logic [31:0]    second;
    } roots_t;

    int error_count = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Truncating division, saturated to the 32-bit signed result range.
    function automatic logic [31:0] div_saturate(input logic signed [63:0] num,
                                                 input logic signed [63:0] den);
        logic [63:0] q;
        logic        neg;
        q = (num < 0 ? -num : num) / (den < 0 ? -den : den);
        neg = (num < 0) != (den < 0);
        if (neg)
        begin
            if (q > 64'h8000_0000)
                q = 64'h8000_0000;
            return 32'(-q);
        end
        if (q > 64'h7fff_ffff)
            q = 64'h7fff_ffff;
        return q[31:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [127:0] x);
        logic [127:0] root;
        logic [127:0] trial;
        root = 0;
        for (int k = 63; k >= 0; k--)
        begin
            trial = root | (128'd1 << k);
            if (trial * trial <= x)
                root = trial;
        end
        return root[63:0];
    endfunction

    function automatic roots_t solve_roots(input logic signed [15:0] a,
                                           input logic signed [15:0] b,
                                           input logic signed [15:0] c);
        roots_t            r;
        logic signed [63:0] disc;
        logic signed [63:0] den;
        logic signed [63:0] nb;
        logic signed [63:0] s;
        if (a == 0)
        begin
            r.kind = qrs_pkg::KIND_A_ZERO;
            r.first = 0;
            r.second = 0;
            return r;
        end
        disc = 64'(b) * 64'(b) - 64'sd4 * 64'(a) * 64'(c);
        den = 64'sd2 * 64'(a);
        nb = -64'(b) * 64'sd65536;
        if (disc == 0)
        begin
            r.kind = qrs_pkg::KIND_DOUBLE;
            r.first = div_saturate(nb, den);
            r.second = r.first;
            return r;
        end
        s = $signed(floor_sqrt(128'(disc < 0 ? -disc : disc) << 32));
        if (disc < 0)
        begin
            r.kind = qrs_pkg::KIND_COMPLEX;
            r.first = div_saturate(nb, den);
            r.second = div_saturate(s, den);
        end
        else
        begin
            r.kind = qrs_pkg::KIND_TWO_REAL;
            r.first = div_saturate(nb + s, den);
            r.second = div_saturate(nb - s, den);
        end
        return r;
    endfunction

    class root_scoreboard;
        roots_t pending_roots[$];

        function void note_coefs(logic signed [15:0] a, logic signed [15:0] b,
                                 logic signed [15:0] c);
            pending_roots.push_back(solve_roots(a, b, c));
        endfunction

        task check_roots(logic [1:0] kind, logic [31:0] first, logic [31:0] second);
            roots_t want;
            if (pending_roots.size() == 0)
            begin
                report_mismatch("unexpected transfer", {30'd0, kind}, 32'd0);
                return;
            end
            want = pending_roots.pop_front();
            if (kind != want.kind)
                report_mismatch("root_kind", {30'd0, kind}, {30'd0, want.kind});
            if (first != want.first)
                report_mismatch("first_value", first, want.first);
            if (second != want.second)
                report_mismatch("second_value", second, want.second);
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic signed [15:0] coef_a = 0;
    logic signed [15:0] coef_b = 0;
    logic signed [15:0] coef_c = 0;
    logic out_valid;
    logic out_stall = 0;
    logic [1:0] root_kind;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    bit stimulus_done = 0;
    int cycle_count = 0;
    int out_wait = 0;
    root_scoreboard board = new();

    quadratic_root_solver uut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    task automatic send_coefs(input logic signed [15:0] a, input logic signed [15:0] b,
                              input logic signed [15:0] c);
        int gap;
        gap = $urandom_range(3) == 0 ? 0 : $urandom_range(10);
        if (gap != 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        coef_a <= a;
        coef_b <= b;
        coef_c <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_coefs(a, b, c);
    endtask

    function automatic logic signed [15:0] random_coef();
        case ($urandom_range(5))
            0: return 16'($urandom_range(16) - 8);
            1: return 16'($urandom_range(1024) - 512);
            2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Output side: a wait drawn per result, with quiet stretches.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                board.check_roots(root_kind, first_value, second_value);
                out_wait = (cycle_count / 2000) % 3 == 0 ? 0 : $urandom_range(10);
            end
            else if (out_wait > 0)
                out_wait--;
            out_stall <= (out_wait != 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        logic signed [15:0] a;
        logic signed [15:0] b;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_coefs(16'sh0000, 16'sh0100, 16'sh0100);    // a zero
        send_coefs(16'sh0100, 16'shfd00, 16'sh0200);    // two real roots
        send_coefs(16'sh0100, 16'sh0000, 16'sh0100);    // complex pair
        send_coefs(16'sh0100, 16'shfe00, 16'sh0100);    // double root
        send_coefs(16'shff00, 16'sh0000, 16'sh0100);    // negative a
        send_coefs(16'sh0001, 16'sh7fff, 16'sh0000);    // largest positive b, roots in range
        send_coefs(16'sh0001, 16'sh8000, 16'sh0000);
        send_coefs(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_coefs(16'sh8000, 16'sh8000, 16'sh8000);
        send_coefs(16'sh8000, 16'sh7fff, 16'sh7fff);
        send_coefs(16'sh7fff, 16'sh8000, 16'sh8000);
        send_coefs(16'sh0001, 16'sh0000, 16'sh8000);
        send_coefs(16'shffff, 16'shffff, 16'shffff);
        send_coefs(16'sh0001, 16'sh0002, 16'sh0001);
        // Hold off until the pipeline has drained completely.
        in_valid <= 0;
        while (board.pending_roots.size() != 0) @(posedge clk);
        for (int i = 0; i < 1040; i++)
        begin
            a = random_coef();
            b = random_coef();
            if (i % 7 == 0 && a != 0 && b[0] == 0)
            begin
                // Force a zero discriminant: c = b*b / (4a) for b = 2ak.
                b = 16'(2 * a * $signed(16'($urandom_range(6) - 3)));
                send_coefs(a, b, 16'(int'(b) * int'(b) / (4 * int'(a))));
            end
            else
                send_coefs(a, b, random_coef());
        end
        in_valid <= 0;
        while (board.pending_roots.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/qrs_pkg.sv
rtl/qrs_front.sv
rtl/qrs_sqrt_cell.sv
rtl/qrs_div_cell.sv
rtl/quadratic_root_solver.sv
rtl/qrs_checker.sv
test/quadratic_root_solver_tb.sv
